/* rtl/fixed_point_point_projection_unit_assert.svh */
// Assertion macros for the self-checks of the projection unit.
// Depends on nothing; included by fpp_back, which checks itself.
`ifndef FIXED_POINT_POINT_PROJECTION_UNIT_ASSERT_SVH
`define FIXED_POINT_POINT_PROJECTION_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define FPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define FPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/fpp_pkg.sv */
// Package of the projection unit: widths, constants and shared types.
// Depends on nothing; imported by all modules of the unit.
package fpp_pkg;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int NEAR_LIMIT_DEF    = 8192;
    localparam int VIS_LIMIT         = 256;
    localparam int SCALE_NUM         = 32'h0200_0000;
    localparam int SCALE_MAX         = 4096;
    localparam int DIV_STEPS         = 32;
    localparam int QUEUE_DEPTH       = 4;

    typedef enum logic [2:0] {
        REG_ROW0 = 3'd0, REG_ROW1 = 3'd1, REG_ROW2 = 3'd2, REG_OFFX = 3'd3,
        REG_OFFY = 3'd4, REG_OFFZ = 3'd5, REG_CENX = 3'd6, REG_CENY = 3'd7
    } t_reg_idx;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic [31:0] cam_x;
        logic [31:0] cam_y;
        logic [31:0] cam_z;
        logic [31:0] vis_num;
        logic        near_ok;
    } t_item;

    // Status from the front part to the queue.
    typedef struct packed {
        logic valid;
    } t_link;
endpackage

/* rtl/fpp_front.sv */
// Front part: shift, matrix transform and near classification, 3 stages.
// Depends on fpp_pkg.
module fpp_front import fpp_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int NEAR_LIMIT    = NEAR_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_px,
    input  logic [31:0] i_ph,
    input  logic [31:0] i_pz,
    input  logic [47:0] i_row0,
    input  logic [47:0] i_row1,
    input  logic [47:0] i_row2,
    input  logic [31:0] i_offx,
    input  logic [31:0] i_offy,
    input  logic [31:0] i_offz,
    output t_item       o_item,
    output t_link       o_link,
    input  logic        i_down_ready
);
    localparam logic [31:0] FMASK = 32'hFFFF_FFFF << FRACTION_BITS;
    localparam logic signed [32:0] NEAR_S = 33'(NEAR_LIMIT);

    logic       r_v1, r_v2, r_v3;
    logic       adv;
    logic [31:0] r_p [3];
    logic [31:0] r_prod [3][3];
    t_item       r_item;

    assign adv = !r_v3 || i_down_ready;
    assign o_ready = adv;

    // Stage 1: pre-shift coordinates.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p[0] <= 32'($signed(i_px) >>> FRACTION_BITS);
            r_p[1] <= 32'($signed(i_ph) >>> FRACTION_BITS);
            r_p[2] <= 32'($signed(i_pz) >>> FRACTION_BITS);
        end
    end

    // Stage 2: nine 16x32 products modulo 2^32.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[0][j] <= 32'($signed(i_row0[16*j +: 16]) * $signed(r_p[j]));
                r_prod[1][j] <= 32'($signed(i_row1[16*j +: 16]) * $signed(r_p[j]));
                r_prod[2][j] <= 32'($signed(i_row2[16*j +: 16]) * $signed(r_p[j]));
            end
        end
    end

    // Stage 3: row sums and near test.
    logic [31:0] n_sum [3];
    logic [31:0] n_num;
    always_comb begin
        n_sum[0] = i_offx;
        n_sum[1] = i_offy;
        n_sum[2] = i_offz;
        n_num    = i_offx << FRACTION_BITS;
        for (int j = 0; j < 3; j++) begin
            n_sum[0] = n_sum[0] + 32'($signed(r_prod[0][j]) >>> FRACTION_BITS);
            n_sum[1] = n_sum[1] + 32'($signed(r_prod[1][j]) >>> FRACTION_BITS);
            n_sum[2] = n_sum[2] + 32'($signed(r_prod[2][j]) >>> FRACTION_BITS);
            n_num    = n_num + (r_prod[0][j] & FMASK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_item.cam_x   <= n_sum[0];
            r_item.cam_y   <= n_sum[1];
            r_item.cam_z   <= n_sum[2];
            r_item.vis_num <= n_num;
            r_item.near_ok <= ($signed({n_sum[2][31], n_sum[2]}) >= NEAR_S)
                              && !n_sum[2][31] && (n_sum[2] != 32'd0);
        end
    end

    // Valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_item       = r_item;
    assign o_link.valid = r_v3;
endmodule

/* rtl/fpp_queue.sv */
// Short queue between front and back parts.
// Depends on fpp_pkg.
module fpp_queue import fpp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    localparam int AW = $clog2(DEPTH);
    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rp];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

/* rtl/fpp_back.sv */
// Back part: pipelined radix-2 dividers, screen mapping and output register.
// Depends on fpp_pkg and the assertion macro header.
`include "fixed_point_point_projection_unit_assert.svh"
module fpp_back import fpp_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    input  logic [9:0]  i_cenx,
    input  logic [9:0]  i_ceny,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_cam_x,
    output logic [31:0] o_cam_y,
    output logic [31:0] o_cam_z,
    output logic        o_visible,
    output logic [31:0] o_screen_x,
    output logic [31:0] o_screen_y,
    output logic [12:0] o_scale
);
    localparam int N = DIV_STEPS;
    localparam int NQ = 4;   // vis, x, y, scale

    logic adv;
    logic r_v [N+1];
    t_item r_it [N+1];
    logic [31:0] r_d  [N+1];
    logic [31:0] r_n  [N+1][NQ];
    logic [31:0] r_r  [N+1][NQ];
    logic        r_ng [N+1][NQ];
    logic r_ov;

    assign adv = !r_ov || i_ready;
    assign o_ready = adv;

    // Stage 0: magnitudes of the dividends; depth is positive when used.
    logic [31:0] n_num [NQ];
    always_comb begin
        n_num[0] = i_item.vis_num;
        n_num[1] = i_item.cam_x << FRACTION_BITS;
        n_num[2] = i_item.cam_y << FRACTION_BITS;
        n_num[3] = 32'(SCALE_NUM);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_it[0] <= i_item;
            r_d[0]  <= i_item.near_ok ? i_item.cam_z : 32'd1;
            for (int k = 0; k < NQ; k++) begin
                r_ng[0][k] <= n_num[k][31];
                r_n[0][k]  <= n_num[k][31] ? 32'(-n_num[k]) : n_num[k];
                r_r[0][k]  <= '0;
            end
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar s = 0; s < N; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_it[s+1] <= r_it[s];
                r_d[s+1]  <= r_d[s];
                for (int k = 0; k < NQ; k++) begin
                    logic [32:0] t;
                    t = {r_r[s][k], r_n[s][k][31]};
                    r_ng[s+1][k] <= r_ng[s][k];
                    if (t >= {1'b0, r_d[s]}) begin
                        r_r[s+1][k] <= 32'(t - {1'b0, r_d[s]});
                        r_n[s+1][k] <= {r_n[s][k][30:0], 1'b1};
                    end else begin
                        r_r[s+1][k] <= t[31:0];
                        r_n[s+1][k] <= {r_n[s][k][30:0], 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= N; s++) r_v[s] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int s = 0; s < N; s++) r_v[s+1] <= r_v[s];
        end
    end

    // Sign fix and screen mapping into the output register.
    logic [31:0] q [NQ];
    logic        near;
    always_comb begin
        for (int k = 0; k < NQ; k++)
            q[k] = r_ng[N][k] ? 32'(-r_n[N][k]) : r_n[N][k];
        near = r_it[N].near_ok;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_cam_x    <= r_it[N].cam_x;
            o_cam_y    <= r_it[N].cam_y;
            o_cam_z    <= r_it[N].cam_z;
            o_visible  <= near && ($signed(q[0]) > -VIS_LIMIT)
                          && ($signed(q[0]) < VIS_LIMIT);
            o_screen_x <= near ? 32'({22'd0, i_cenx}) + q[1] : 32'd0;
            o_screen_y <= near ? 32'({22'd0, i_ceny}) - q[2] : 32'd0;
            o_scale    <= !near ? 13'd0 :
                          (q[3] > 32'(SCALE_MAX)) ? 13'(SCALE_MAX) : q[3][12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_v[N];
    end
    assign o_valid = r_ov;

    `FPP_ASSERT_IMP(a_vis_front, i_clk, i_rst_n, o_valid && o_visible, !o_cam_z[31] && o_cam_z != 32'd0, "visible point not in front")
    `FPP_ASSERT_IMP(a_scale_max, i_clk, i_rst_n, o_valid, o_scale <= 13'(SCALE_MAX), "scale beyond limit")
    `FPP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_cam_z), "result lost")
endmodule

/* rtl/fixed_point_point_projection_unit.sv */
// Projection unit: an accepted point passes 3 front stages, the queue,
// 33 divide stages and 1 output register; each divide stage after the
// first gives a quotient bit. Throughput one point per cycle unless stalled.
// Configuration may be written while idle; reset restores register defaults
// and empties the pipeline and queue, synchronous active-low.
// Depends on fpp_pkg, fpp_front, fpp_queue, fpp_back.
module fixed_point_point_projection_unit import fpp_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int NEAR_LIMIT    = NEAR_LIMIT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // pos_x, pos_height, pos_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // cam_x, cam_y, cam_depth, visible, screen_x, screen_y, sprite_scale, pad
    output logic [175:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [47:0]  i_cfg_data
);
    logic [47:0] r_row0, r_row1, r_row2;
    logic [31:0] r_offx, r_offy, r_offz;
    logic [9:0]  r_cenx, r_ceny;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0 <= 48'h100;
            r_row1 <= 48'h100_0000;
            r_row2 <= 48'h100_0000_0000;
            r_offx <= '0;
            r_offy <= '0;
            r_offz <= '0;
            r_cenx <= 10'd212;
            r_ceny <= 10'd120;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ROW0: r_row0 <= i_cfg_data;
                REG_ROW1: r_row1 <= i_cfg_data;
                REG_ROW2: r_row2 <= i_cfg_data;
                REG_OFFX: r_offx <= i_cfg_data[31:0];
                REG_OFFY: r_offy <= i_cfg_data[31:0];
                REG_OFFZ: r_offz <= i_cfg_data[31:0];
                REG_CENX: r_cenx <= i_cfg_data[9:0];
                REG_CENY: r_ceny <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    t_item f_item, q_item;
    t_link f_link;
    logic  q_in_ready, q_valid, b_ready;

    fpp_front #(.FRACTION_BITS(FRACTION_BITS), .NEAR_LIMIT(NEAR_LIMIT)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_px(s_axis_tdata[31:0]), .i_ph(s_axis_tdata[63:32]), .i_pz(s_axis_tdata[95:64]),
        .i_row0(r_row0), .i_row1(r_row1), .i_row2(r_row2),
        .i_offx(r_offx), .i_offy(r_offy), .i_offz(r_offz),
        .o_item(f_item), .o_link(f_link), .i_down_ready(q_in_ready)
    );

    fpp_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_link.valid), .o_ready(q_in_ready), .i_item(f_item),
        .o_valid(q_valid), .i_ready(b_ready), .o_item(q_item)
    );

    logic [31:0] cx, cy, cz, sx, sy;
    logic        vis;
    logic [12:0] sc;

    fpp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(b_ready), .i_item(q_item),
        .i_cenx(r_cenx), .i_ceny(r_ceny),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_cam_x(cx), .o_cam_y(cy), .o_cam_z(cz), .o_visible(vis),
        .o_screen_x(sx), .o_screen_y(sy), .o_scale(sc)
    );

    assign m_axis_tdata = {2'b00, sc, sy, sx, vis, cz, cy, cx};
endmodule
